/* rtl/core/cfcs_pkg.sv */
// Shared types, constants and the CRC byte update for the coordinate frame serializer.
// No dependencies.
package cfcs_pkg;

  localparam int FRAME_LEN = 24;
  localparam int CRC_SPAN  = 22;
  localparam int BODY_BITS = CRC_SPAN * 8;

  localparam logic [4:0] POS_CRC_LO = 5'(CRC_SPAN);
  localparam logic [4:0] POS_LAST   = 5'(FRAME_LEN - 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Q32.16 product limits and rounding constant
  localparam logic [47:0] HALF_Q16  = 48'h0000_0000_8000;
  localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_0000;
  localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

  localparam logic [7:0]  RST_START_FIRST  = 8'hAA;
  localparam logic [7:0]  RST_START_SECOND = 8'h55;
  localparam logic [7:0]  RST_VERSION      = 8'h01;
  localparam logic [7:0]  RST_KIND         = 8'h01;
  localparam logic [15:0] RST_SCALE        = 16'd1000;

  localparam logic [7:0]  FLAGS_BYTE = 8'h00;

  typedef enum logic [2:0] {
    REG_START_FIRST  = 3'd0,
    REG_START_SECOND = 3'd1,
    REG_VERSION      = 3'd2,
    REG_KIND         = 3'd3,
    REG_SCALE        = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] version;
    logic [7:0] kind;
  } hdr_cfg_t;

  typedef struct packed {
    logic        err;
    logic [31:0] pair;
    logic [7:0]  cls;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/core/cfcs_front.sv */
// Front end: registers a point, scales x/y/z by the configured factor, rounds and range checks.
// Three stages: magnitude, multiply, round/check. Depends on cfcs_pkg.
module cfcs_front import cfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [31:0] pair_number,
  input  logic [31:0] class_number,
  input  logic [31:0] x_coord,
  input  logic [31:0] y_coord,
  input  logic [31:0] z_coord,
  input  logic [15:0] scale,
  output logic        pt_valid,
  output point_t      pt,
  output logic [1:0]  busy
);

  logic [31:0]       coord_in [3];

  // stage 1
  logic              s1_v_r;
  logic [2:0][31:0]  s1_mag_r;
  logic [2:0]        s1_neg_r;
  logic [31:0]       s1_pair_r;
  logic [7:0]        s1_cls_r;
  logic              s1_cls_bad_r;
  // stage 2
  logic              s2_v_r;
  logic [2:0][47:0]  s2_prod_r;
  logic [2:0]        s2_neg_r;
  logic [31:0]       s2_pair_r;
  logic [7:0]        s2_cls_r;
  logic              s2_cls_bad_r;
  // stage 3
  logic              s3_v_r;
  point_t            s3_pt_r;

  logic [2:0]        over;
  logic [2:0][31:0]  fixed;
  logic [48:0]       rsum [3];

  assign coord_in[0] = x_coord;
  assign coord_in[1] = y_coord;
  assign coord_in[2] = z_coord;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_r[i] <= coord_in[i][31];
      s1_mag_r[i] <= coord_in[i][31] ? (32'd0 - coord_in[i]) : coord_in[i];
    end
    s1_pair_r    <= pair_number;
    s1_cls_r     <= class_number[7:0];
    s1_cls_bad_r <= |class_number[31:8];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_prod_r[i] <= 48'(s1_mag_r[i]) * 48'(scale);
    end
    s2_neg_r     <= s1_neg_r;
    s2_pair_r    <= s1_pair_r;
    s2_cls_r     <= s1_cls_r;
    s2_cls_bad_r <= s1_cls_bad_r;
  end

  // Within the limits the rounded magnitude never exceeds 2^31, so no clamp is needed.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      over[i]  = s2_neg_r[i] ? (s2_prod_r[i] > NEG_LIMIT) : (s2_prod_r[i] > POS_LIMIT);
      rsum[i]  = 49'(s2_prod_r[i]) + 49'(HALF_Q16);
      fixed[i] = s2_neg_r[i] ? (32'd0 - rsum[i][47:16]) : rsum[i][47:16];
    end
  end

  always_ff @(posedge clk) begin
    s3_pt_r.err  <= s2_cls_bad_r | (|over);
    s3_pt_r.pair <= s2_pair_r;
    s3_pt_r.cls  <= s2_cls_r;
    s3_pt_r.x    <= fixed[0];
    s3_pt_r.y    <= fixed[1];
    s3_pt_r.z    <= fixed[2];
  end

  assign pt_valid = s3_v_r;
  assign pt       = s3_pt_r;
  assign busy     = 2'(s1_v_r) + 2'(s2_v_r) + 2'(s3_v_r);

endmodule

/* rtl/core/cfcs_fifo.sv */
// Point queue between the scaling front end and the byte serializer.
// Register based, head readable every cycle. Depends on cfcs_pkg.
module cfcs_fifo import cfcs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  point_t                     wr_data,
  input  logic                       rd_en,
  output point_t                     rd_data,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  point_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) count_nxt = count_r + CW'(1);
    if (rd_en && !wr_en) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
      if (rd_en) rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  assign rd_data  = mem_r[rd_ptr_r];
  assign nonempty = (count_r != '0);
  assign count    = count_r;

endmodule

/* rtl/core/cfcs_back.sv */
// Back end: walks the head point through its 24-byte frame, one byte per transfer,
// folding bytes 0..21 into the CRC. Depends on cfcs_pkg.
module cfcs_back import cfcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  point_t     head,
  input  logic       head_valid,
  input  logic       pop,
  input  hdr_cfg_t   hdr,
  output logic [7:0] frame_byte,
  output logic       last_byte,
  output logic       status,
  output logic       head_done
);

  logic [4:0]           pos_r, pos_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [BODY_BITS-1:0] body;
  logic [7:0]           cur_byte;
  logic                 xfer;

  // byte 0 in the low bits; multi-byte fields fall out little-endian
  assign body = {head.z, head.y, head.x, FLAGS_BYTE, head.cls, head.pair,
                 hdr.kind, hdr.version, hdr.start_second, hdr.start_first};

  always_comb begin
    if (pos_r < POS_CRC_LO) cur_byte = body[{pos_r, 3'b000} +: 8];
    else if (pos_r == POS_CRC_LO) cur_byte = crc_r[7:0];
    else cur_byte = crc_r[15:8];
  end

  assign xfer       = pop && head_valid;
  assign last_byte  = head.err || (pos_r == POS_LAST);
  assign status     = head.err;
  assign frame_byte = head.err ? 8'h00 : cur_byte;
  assign head_done  = xfer && last_byte;

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (xfer) begin
      if (last_byte) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        pos_nxt = pos_r + 5'd1;
        if (pos_r < POS_CRC_LO) crc_nxt = crc_byte(crc_r, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= CRC_INIT;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

endmodule

/* rtl/core/coordinate_frame_crc_serializer.sv */
// Point-to-frame serializer: each accepted point (pair, class, x/y/z in Q16.16 mm) is scaled,
// rounded half away from zero and sent as a 24-byte frame ending in a CRC-16/CCITT-FALSE,
// one byte per pop; a point with class above 255 or a scaled coordinate outside int32 gives one
// error result instead. A point is scaled, then waits in a FIFO_DEPTH-entry queue; the byte
// serializer takes the next point only after the current frame's last byte is popped. A point
// holds its queue credit from when it is taken until its result is popped, so a run of
// rejected points moves at one per cycle (pop held high) only when FIFO_DEPTH is 5 or more,
// not with the default depth. Points are taken every cycle while pipeline plus queue hold
// fewer than FIFO_DEPTH points. Depends on cfcs_pkg, cfcs_front, cfcs_fifo, cfcs_back.
module coordinate_frame_crc_serializer import cfcs_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_pair_number,
  input  logic [31:0] in_class_number,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_y_coord,
  input  logic [31:0] in_z_coord,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte,
  output logic        out_status
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = CW + 2;

  hdr_cfg_t       hdr_r;
  logic [15:0]    scale_r;
  logic           take;
  logic           pt_valid;
  point_t         pt;
  logic [1:0]     busy;
  point_t         head;
  logic           head_valid;
  logic           head_done;
  logic [CW-1:0]  q_count;
  logic [SW-1:0]  in_flight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r.start_first  <= RST_START_FIRST;
      hdr_r.start_second <= RST_START_SECOND;
      hdr_r.version      <= RST_VERSION;
      hdr_r.kind         <= RST_KIND;
      scale_r            <= RST_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_FIRST:  hdr_r.start_first  <= cfg_wdata[7:0];
        REG_START_SECOND: hdr_r.start_second <= cfg_wdata[7:0];
        REG_VERSION:      hdr_r.version      <= cfg_wdata[7:0];
        REG_KIND:         hdr_r.kind         <= cfg_wdata[7:0];
        REG_SCALE:        scale_r            <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // credit check: every point in the pipeline already owns a queue slot
  assign in_flight = SW'(busy) + SW'(q_count);
  assign full      = (in_flight >= SW'(FIFO_DEPTH));
  assign take      = push && !full;

  cfcs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .pair_number  (in_pair_number),
    .class_number (in_class_number),
    .x_coord      (in_x_coord),
    .y_coord      (in_y_coord),
    .z_coord      (in_z_coord),
    .scale        (scale_r),
    .pt_valid     (pt_valid),
    .pt           (pt),
    .busy         (busy)
  );

  cfcs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (pt_valid),
    .wr_data  (pt),
    .rd_en    (head_done),
    .rd_data  (head),
    .nonempty (head_valid),
    .count    (q_count)
  );

  cfcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .hdr        (hdr_r),
    .frame_byte (out_frame_byte),
    .last_byte  (out_last_byte),
    .status     (out_status),
    .head_done  (head_done)
  );

  assign empty = !head_valid;

endmodule

/* rtl/core/cfcs_checker.sv */
// Port-level checks for coordinate_frame_crc_serializer, attached by bind.
// Depends only on the top level's ports.
module cfcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_frame_byte,
  input logic        out_last_byte,
  input logic        out_status
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queue not empty or input blocked after reset");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status) |-> out_last_byte)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status) |-> (out_frame_byte == 8'h00))
    else $error("error result carries a nonzero byte");

  // rest of a frame is already queued once its first byte is out
  a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last_byte) |=> !empty && !out_status)
    else $error("frame broken off before its last byte");

endmodule

bind coordinate_frame_crc_serializer cfcs_checker u_cfcs_checker (.*);
